// ----- rtl/core/circular_double_ended_queue_core_macros.svh -----
// Assertion macros used by the deque core file.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deque core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deque core check failed");

`endif

// ----- rtl/core/cdeq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque core package
// Request, status and cell operation codes shared by the deque core files.
// ----------------------------------------------------------------------------
package cdeq_pkg;

	localparam logic [1:0] REQ_PUSH_HEAD   = 2'd0;
	localparam logic [1:0] REQ_POP_HEAD    = 2'd1;
	localparam logic [1:0] REQ_INJECT_TAIL = 2'd2;
	localparam logic [1:0] REQ_EJECT_TAIL  = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int unsigned CAP_W     = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd63;

	// Operation broadcast to every cell of the row.
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_PUSH   = 3'd1,
		CELL_POP    = 3'd2,
		CELL_INJECT = 3'd3,
		CELL_EJECT  = 3'd4,
		CELL_CLEAR  = 3'd5
	} cell_op_t;

endpackage

// ----- rtl/core/cdeq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque cell
// One slot of the deque row: a word and an occupied flag. Shifts toward the
// tail on a head push, toward the head on a head pop, and takes or drops the
// word when it is the tail boundary; a clear empties it.
// ----------------------------------------------------------------------------
module cdeq_cell #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdeq_pkg::cell_op_t     op,
	input  logic [DATA_WIDTH-1:0]  data_in,
	input  logic [DATA_WIDTH-1:0]  left_data,
	input  logic                   left_occ,
	input  logic [DATA_WIDTH-1:0]  right_data,
	input  logic                   right_occ,
	output logic [DATA_WIDTH-1:0]  data,
	output logic                   occ,
	output logic                   is_tail
);
	import cdeq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  occ_q;

	assign data    = data_q;
	assign occ     = occ_q;
	assign is_tail = occ_q & ~right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (op)
				CELL_PUSH: occ_q <= left_occ;
				CELL_POP: occ_q <= right_occ;
				CELL_INJECT: begin
					if (left_occ && !occ_q) occ_q <= 1'b1;
				end
				CELL_EJECT: begin
					if (occ_q && !right_occ) occ_q <= 1'b0;
				end
				CELL_CLEAR: occ_q <= 1'b0;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: data_q <= left_data;
			CELL_POP: data_q <= right_data;
			CELL_INJECT: begin
				if (left_occ && !occ_q) data_q <= data_in;
			end
			default: data_q <= data_q;
		endcase
	end

endmodule

// ----- rtl/core/circular_double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core
// Deque of signed words held in a row of cells, head at cell 0. Head requests
// shift the whole row, tail requests act on the boundary cell.
// ----------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------
//  request   | start, busy (always low)     | req_type, data_in
//  result    | done (one-cycle strobe)      | status, data_out
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One request per cycle; its result appears from the output register on the cycle
// after acceptance, except for a request that meets a capacity write.
// Reset empties the deque and sets capacity to 63; no clearing pass is needed.
// A capacity write empties the deque. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "circular_double_ended_queue_core_macros.svh"

module circular_double_ended_queue_core #(
	parameter int unsigned SLOTS      = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] data_in,
	output logic                         done,
	output logic [1:0]                   status,
	output logic signed [DATA_WIDTH-1:0] data_out,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cdeq_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CW    = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

	logic [CAP_W-1:0]      cap_q;
	logic                  cfg_wr;
	logic                  accept;
	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         cap_min1;
	logic [CW-1:0]         cap_eff;
	logic [IDX_W-1:0]      full_idx;
	logic                  is_full;
	logic                  is_empty;
	cell_op_t              op;
	logic [1:0]            status_d;
	logic [DATA_WIDTH-1:0] result_d;
	logic [DATA_WIDTH-1:0] tail_data;
	logic [DATA_WIDTH-1:0] cell_data [SLOTS];
	logic [SLOTS-1:0]      occ_vec;
	logic [SLOTS-1:0]      tail_vec;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] data_out_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {{(32 - CAP_W){1'b0}}, cap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Usable depth: zero acts as one, capped at one less than the row length.
	always_comb begin
		cap_ext  = CW'(cap_q);
		cap_min1 = (cap_ext == '0) ? CW'(1) : cap_ext;
		cap_eff  = (cap_min1 > CW'(SLOTS - 1)) ? CW'(SLOTS - 1) : cap_min1;
		full_idx = IDX_W'(cap_eff - CW'(1));
	end

	assign is_full  = occ_vec[full_idx];
	assign is_empty = ~occ_vec[0];

	always_comb begin
		tail_data = '0;
		for (int i = 0; i < SLOTS; i++) begin
			tail_data = tail_data | (cell_data[i] & {DATA_WIDTH{tail_vec[i]}});
		end
	end

	always_comb begin
		op       = CELL_HOLD;
		status_d = STATUS_OK;
		result_d = '0;
		if (cfg_wr) begin
			op = CELL_CLEAR;
		end else if (accept) begin
			case (req_type)
				REQ_PUSH_HEAD: begin
					if (is_full) status_d = STATUS_FULL;
					else op = CELL_PUSH;
				end
				REQ_POP_HEAD: begin
					if (is_empty) begin
						status_d = STATUS_EMPTY;
					end else begin
						op       = CELL_POP;
						result_d = cell_data[0];
					end
				end
				REQ_INJECT_TAIL: begin
					if (is_full) status_d = STATUS_FULL;
					else op = CELL_INJECT;
				end
				REQ_EJECT_TAIL: begin
					if (is_empty) begin
						status_d = STATUS_EMPTY;
					end else begin
						op       = CELL_EJECT;
						result_d = tail_data;
					end
				end
				default: op = CELL_HOLD;
			endcase
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic                  left_occ;
		logic [DATA_WIDTH-1:0] right_data;
		logic                  right_occ;

		if (g == 0) begin : g_head
			assign left_data = data_in;
			assign left_occ  = 1'b1;
		end else begin : g_mid
			assign left_data = cell_data[g-1];
			assign left_occ  = occ_vec[g-1];
		end

		if (g == SLOTS - 1) begin : g_end
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_next
			assign right_data = cell_data[g+1];
			assign right_occ  = occ_vec[g+1];
		end

		cdeq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.data_in    (data_in),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.data       (cell_data[g]),
			.occ        (occ_vec[g]),
			.is_tail    (tail_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
		end else begin
			done_q   <= accept & ~cfg_wr;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		data_out_q <= result_d;
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = data_out_q;

	// Occupied cells always form a run starting at the head.
	`CDEQ_ASSERT_NOW(a_occ_run, clk, arst_n, 1'b1, (occ_vec & (occ_vec + 1'b1)) == '0)
	`CDEQ_ASSERT_NOW(a_within_cap, clk, arst_n, 1'b1, $countones(occ_vec) <= int'(cap_eff))
	`CDEQ_ASSERT_NEXT(a_result_follows, clk, arst_n, accept && !cfg_wr, done)
	`CDEQ_ASSERT_NOW(a_refused_zero, clk, arst_n, done && (status != STATUS_OK),
		data_out == '0)

endmodule

// ----- tb/circular_double_ended_queue_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop, inject and eject requests across several capacity
// settings, directed first and then random, and checks every result strobe
// against a deque model kept in a queue or a fixed directed expectation.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_core_test;

	import cdeq_pkg::*;

	localparam logic [2:0]  ADDR_CAPACITY = 3'd0;
	localparam logic [2:0]  ADDR_SPARE    = 3'd4;
	localparam int unsigned PHASE_ITEMS   = 206;
	localparam int unsigned QUIET_TAIL    = 150;
	localparam int unsigned STALL_LIMIT   = 500;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] word;
	} deq_result_t;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [1:0]         op;
		logic signed [31:0] word;
		logic [2:0]         addr;
		logic               typed;
		logic [1:0]         exp_status;
		logic signed [31:0] exp_word;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] req_type;
	logic signed [31:0] data_in;
	logic done;
	logic [1:0] status;
	logic signed [31:0] data_out;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// fixed expectation for the request now on the bus, if any
	logic row_typed;
	logic [1:0] typed_status;
	logic signed [31:0] typed_word;

	deq_result_t expected_q[$];
	logic signed [31:0] deque_words[$];
	int unsigned deque_limit = 63;
	logic [5:0] cap_setting = CAP_RESET;
	bit failed = 1'b0;
	int unsigned idle_cycles = 0;

	circular_double_ended_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.data_in  (data_in),
		.done     (done),
		.status   (status),
		.data_out (data_out),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	// Apply one request to the deque model and return its result.
	function automatic deq_result_t deque_apply(input logic [1:0] op,
			input logic signed [31:0] word);
		deq_result_t r;
		r.status = STATUS_OK;
		r.word   = '0;
		case (op)
			REQ_PUSH_HEAD: begin
				if (deque_words.size() >= deque_limit) r.status = STATUS_FULL;
				else deque_words.push_front(word);
			end
			REQ_INJECT_TAIL: begin
				if (deque_words.size() >= deque_limit) r.status = STATUS_FULL;
				else deque_words.push_back(word);
			end
			REQ_POP_HEAD: begin
				if (deque_words.size() == 0) r.status = STATUS_EMPTY;
				else r.word = deque_words.pop_front();
			end
			default: begin
				if (deque_words.size() == 0) r.status = STATUS_EMPTY;
				else r.word = deque_words.pop_back();
			end
		endcase
		return r;
	endfunction

	function automatic stim_row_t req_row(input logic [1:0] op, input logic signed [31:0] word,
			input logic typed, input logic [1:0] st, input logic signed [31:0] wd);
		stim_row_t row;
		row.kind       = ROW_REQUEST;
		row.op         = op;
		row.word       = word;
		row.addr       = ADDR_CAPACITY;
		row.typed      = typed;
		row.exp_status = st;
		row.exp_word   = wd;
		return row;
	endfunction

	function automatic stim_row_t write_row(input logic [2:0] addr, input logic [31:0] value);
		stim_row_t row;
		row            = req_row(REQ_PUSH_HEAD, value, 1'b0, STATUS_OK, '0);
		row.kind       = ROW_WRITE;
		row.addr       = addr;
		return row;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic signed [31:0] word,
			input logic typed, input logic [1:0] st, input logic signed [31:0] wd);
		@(negedge clk);
		start        <= 1'b1;
		req_type     <= op;
		data_in      <= word;
		row_typed    <= typed;
		typed_status <= st;
		typed_word   <= wd;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Hold requests until every outstanding result has come back.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic is_write, input logic [2:0] addr,
			input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write) begin
			if (addr == ADDR_CAPACITY) begin
				// a capacity write empties the deque; zero acts as one
				cap_setting = value[5:0];
				deque_limit = (value[5:0] == 6'd0) ? 1 : value[5:0];
				deque_words.delete();
			end
		end else if (prdata !== {26'd0, cap_setting}) begin
			$error("prdata: expected %0d, got %0d", cap_setting, prdata);
			failed = 1'b1;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Record accepted requests, then check result strobes against the oldest expectation.
	always @(posedge clk) begin
		deq_result_t exp_r;
		bit active;
		active = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				exp_r = deque_apply(req_type, data_in);
				if (row_typed) begin
					exp_r.status = typed_status;
					exp_r.word   = typed_word;
				end
				expected_q.push_back(exp_r);
				active = 1'b1;
			end
			if (done) begin
				active = 1'b1;
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: status %0d, data_out %0d",
						status, data_out);
					failed = 1'b1;
				end else begin
					exp_r = expected_q.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						failed = 1'b1;
					end
					if (data_out !== exp_r.word) begin
						$error("data_out: expected %0d, got %0d", exp_r.word, data_out);
						failed = 1'b1;
					end
				end
			end
			if (psel && penable && pready) active = 1'b1;
			idle_cycles = active ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		stim_row_t directed[$];
		stim_row_t row;
		int unsigned phase;
		int unsigned n;
		int unsigned chunk_left;
		int unsigned ins_pct;
		logic quiet;
		logic insert;
		logic at_head;
		logic [5:0] cap;
		logic [1:0] op;
		logic signed [31:0] word;

		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_PUSH_HEAD;
		data_in      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = ADDR_CAPACITY;
		pwdata       = '0;
		row_typed    = 1'b0;
		typed_status = STATUS_OK;
		typed_word   = '0;

		directed.push_back(req_row(REQ_POP_HEAD, 0, 1'b1, STATUS_EMPTY, 0));
		directed.push_back(req_row(REQ_EJECT_TAIL, 0, 1'b1, STATUS_EMPTY, 0));
		directed.push_back(req_row(REQ_PUSH_HEAD, 32'h7FFF_FFFF, 1'b1, STATUS_OK, 0));
		directed.push_back(req_row(REQ_INJECT_TAIL, 32'h8000_0000, 1'b1, STATUS_OK, 0));
		directed.push_back(req_row(REQ_POP_HEAD, 0, 1'b1, STATUS_OK, 32'h7FFF_FFFF));
		directed.push_back(req_row(REQ_EJECT_TAIL, 0, 1'b1, STATUS_OK, 32'h8000_0000));
		// a stored all-ones word must come back as data, not as empty
		directed.push_back(req_row(REQ_INJECT_TAIL, -1, 1'b1, STATUS_OK, 0));
		directed.push_back(req_row(REQ_POP_HEAD, 0, 1'b1, STATUS_OK, -1));
		directed.push_back(req_row(REQ_POP_HEAD, 0, 1'b1, STATUS_EMPTY, 0));
		// zero capacity behaves as one element
		directed.push_back(write_row(ADDR_CAPACITY, 32'hFFFF_FFC0));
		directed.push_back(req_row(REQ_PUSH_HEAD, 0, 1'b1, STATUS_OK, 0));
		directed.push_back(req_row(REQ_PUSH_HEAD, 1, 1'b1, STATUS_FULL, 0));
		directed.push_back(req_row(REQ_INJECT_TAIL, 5, 1'b1, STATUS_FULL, 0));
		directed.push_back(req_row(REQ_EJECT_TAIL, 0, 1'b1, STATUS_OK, 0));
		directed.push_back(req_row(REQ_INJECT_TAIL, 32'h5555_5555, 1'b1, STATUS_OK, 0));
		// write to an unmapped register must leave the contents alone
		directed.push_back(write_row(ADDR_SPARE, 32'h0000_0001));
		directed.push_back(req_row(REQ_POP_HEAD, 0, 1'b1, STATUS_OK, 32'h5555_5555));
		directed.push_back(write_row(ADDR_CAPACITY, 32'd2));
		directed.push_back(req_row(REQ_INJECT_TAIL, 32'hAAAA_AAAA, 1'b0, STATUS_OK, 0));
		directed.push_back(req_row(REQ_PUSH_HEAD, 32'h1234_5678, 1'b0, STATUS_OK, 0));
		directed.push_back(req_row(REQ_INJECT_TAIL, 3, 1'b1, STATUS_FULL, 0));
		// rewriting capacity empties a non-empty deque
		directed.push_back(write_row(ADDR_CAPACITY, 32'd2));
		directed.push_back(req_row(REQ_EJECT_TAIL, 0, 1'b1, STATUS_EMPTY, 0));
		directed.push_back(write_row(ADDR_CAPACITY, 32'd63));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_access(1'b0, ADDR_CAPACITY, '0);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.kind == ROW_WRITE) begin
				wait_drained();
				apb_access(1'b1, row.addr, row.word);
				apb_access(1'b0, ADDR_CAPACITY, '0);
			end else begin
				if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 9));
				send_request(row.op, row.word, row.typed, row.exp_status, row.exp_word);
			end
		end

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: cap = 6'd0;
				1: cap = 6'd1;
				2: cap = 6'($urandom_range(2, 9));
				3: cap = 6'($urandom_range(10, 62));
				default: cap = 6'd63;
			endcase
			wait_drained();
			apb_access(1'b1, ADDR_CAPACITY, ($urandom & 32'hFFFF_FFC0) | cap);
			apb_access(1'b0, ADDR_CAPACITY, '0);
			chunk_left = 0;
			ins_pct    = 50;
			quiet      = 1'b0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// alternate fill, drain and mixed stretches
				if (chunk_left == 0) begin
					chunk_left = $urandom_range(8, 80);
					case ($urandom_range(0, 2))
						0: ins_pct = 90;
						1: ins_pct = 10;
						default: ins_pct = 50;
					endcase
					quiet = ($urandom_range(0, 3) == 0);
				end
				chunk_left--;
				if (n == PHASE_ITEMS / 2 && phase != 4) wait_drained();
				if (!quiet && !(phase == 4 && n >= PHASE_ITEMS - QUIET_TAIL) &&
						$urandom_range(0, 5) == 0)
					pause_sender($urandom_range(1, 9));
				insert  = ($urandom_range(0, 99) < ins_pct);
				at_head = 1'($urandom_range(0, 1));
				if (insert) op = at_head ? REQ_PUSH_HEAD : REQ_INJECT_TAIL;
				else op = at_head ? REQ_POP_HEAD : REQ_EJECT_TAIL;
				case ($urandom_range(0, 7))
					0: word = 32'h7FFF_FFFF;
					1: word = 32'h8000_0000;
					2: word = -1;
					3: word = 0;
					default: word = $urandom;
				endcase
				send_request(op, word, 1'b0, STATUS_OK, 0);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (!failed) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cdeq_pkg.sv
rtl/core/cdeq_cell.sv
rtl/core/circular_double_ended_queue_core.sv
tb/circular_double_ended_queue_core_test.sv
